// ===== design/current_filter_pi_controller_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the current filter PI controller
// Concurrent checks clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef CURRENT_FILTER_PI_CONTROLLER_DEFINES_SVH
`define CURRENT_FILTER_PI_CONTROLLER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define CFPI_ASSERT_HOLD(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("cfpi: same-cycle check failed");
// next-cycle implication
`define CFPI_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("cfpi: next-cycle check failed");
`else
`define CFPI_ASSERT_HOLD(label, pre, post)
`define CFPI_ASSERT_NEXT(label, pre, post)
`endif

`endif

// ===== design/cfpi_pkg.sv =====
// ----------------------------------------------------------------------------
// Current filter PI controller package
// Widths, register indexes and reset values shared by the design.
// ----------------------------------------------------------------------------
package cfpi_pkg;

  localparam int WINDOW_DEF   = 32;
  localparam int ADC_BITS_DEF = 12;

  localparam int CUR_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int LIMIT_W = 23;
  localparam int PWM_W   = 10;
  localparam int ZERO_W  = 12;
  localparam int INTEG_W = 25;
  localparam int INC_W   = 27;
  localparam int ACC_W   = 44;
  localparam int PI_FRAC = 24;
  localparam int AMP_SHIFT = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam int USER_W      = 2;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - PWM_W - CUR_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET      = 3'd0,
    REG_PROP_GAIN   = 3'd1,
    REG_INTEG_GAIN  = 3'd2,
    REG_STEP_TIME   = 3'd3,
    REG_INTEG_LIMIT = 3'd4,
    REG_PWM_MAX     = 3'd5,
    REG_ZERO_CODE   = 3'd6,
    REG_ADC_GAIN    = 3'd7
  } cfg_reg_t;

  localparam logic [CUR_W-1:0]   RST_TARGET      = 16'd102;
  localparam logic [GAIN_W-1:0]  RST_PROP_GAIN   = 16'd5120;
  localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN  = 16'd3840;
  localparam logic [GAIN_W-1:0]  RST_STEP_TIME   = 16'd655;
  localparam logic [LIMIT_W-1:0] RST_INTEG_LIMIT = 23'd6553600;
  localparam logic [PWM_W-1:0]   RST_PWM_MAX     = 10'd255;
  localparam logic [ZERO_W-1:0]  RST_ZERO_CODE   = 12'd2048;
  localparam logic [GAIN_W-1:0]  RST_ADC_GAIN    = 16'd1212;

  localparam logic [ACC_W-1:0] TRUNC_BIAS = ACC_W'((64'd1 << PI_FRAC) - 64'd1);

endpackage

// ===== design/current_filter_pi_controller.sv =====
// ----------------------------------------------------------------------------
// Current filter PI controller
// Each input beat converts one ADC sample to Q7.8 amps, updates a moving
// average over WINDOW samples and, on a control tick, runs one PI step. One
// output beat follows each input beat. A beat with a tick passes through the
// PI states as well before its result is presented; the next input beat is
// taken once the result is loaded into the output register. The pace is set
// by the single shared multiplier, which serves the sample conversion, the
// reciprocal division of the window sum and the three PI products in turn, and
// by the registered read of the sample ring memory. One beat is in work at a
// time; the next is accepted while the previous result waits on the output.
// ----------------------------------------------------------------------------
`include "current_filter_pi_controller_defines.svh"

module current_filter_pi_controller
  import cfpi_pkg::*;
#(
  parameter int WINDOW   = WINDOW_DEF,
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [((ADC_BITS+7)/8)*8-1:0]    s_tdata,   // adc_sample
  input  logic [USER_W-1:0]                s_tuser,   // motor_reverse, control_tick
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [OUT_TDATA_W-1:0]           m_tdata,   // filtered_current, pwm_magnitude
  output logic [USER_W-1:0]                m_tuser,   // pwm_reverse, pwm_updated
  input  logic                             cfg_we,
  input  logic [CFG_IDX_W-1:0]             cfg_index,
  input  logic [CFG_DATA_W-1:0]            cfg_data
);

  localparam int POS_W  = $clog2(WINDOW);
  localparam int MAG_W  = CUR_W + POS_W;
  localparam int DIFF_W = ((ADC_BITS > ZERO_W) ? ADC_BITS : ZERO_W) + 1;
  localparam int MUL_W  = (MAG_W + 1 > INTEG_W) ? MAG_W + 1 : INTEG_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int Q_W    = CUR_W + 1;
  localparam int PWMW_W = ACC_W - PI_FRAC;
  localparam logic [MAG_W-1:0] RECIP   = MAG_W'((64'd1 << MAG_W) / WINDOW);
  localparam logic [MAG_W-1:0] WIN_VAL = MAG_W'(WINDOW);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CONV, ST_SUM, ST_DIV, ST_CORR, ST_ERR,
    ST_INT, ST_ACC, ST_PROP, ST_PISUM, ST_PWM, ST_OUT
  } state_t;

  state_t state;

  logic signed [CUR_W-1:0]   target_current;
  logic [GAIN_W-1:0]         prop_gain;
  logic [GAIN_W-1:0]         integ_gain;
  logic [GAIN_W-1:0]         step_time;
  logic [LIMIT_W-1:0]        integral_limit;
  logic [PWM_W-1:0]          pwm_max;
  logic [ZERO_W-1:0]         zero_code;
  logic [GAIN_W-1:0]         adc_gain;

  logic signed [CUR_W-1:0]   ring_mem [WINDOW];
  logic [WINDOW-1:0]         ring_valid;
  logic signed [CUR_W-1:0]   rd_data;
  logic                      rd_valid;
  logic [POS_W-1:0]          ring_pos;

  logic [ADC_BITS-1:0]       sample;
  logic                      reverse;
  logic                      tick;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  pterm;
  logic signed [MAG_W-1:0]   window_sum;
  logic [MAG_W-1:0]          sum_mag;
  logic                      sum_neg;
  logic signed [CUR_W-1:0]   avg;
  logic signed [Q_W-1:0]     err;
  logic signed [INTEG_W-1:0] integral;
  logic signed [ACC_W-1:0]   acc;
  logic [PWM_W-1:0]          held_mag;
  logic                      held_rev;
  logic signed [CUR_W-1:0]   out_cur;
  logic [PWM_W-1:0]          out_mag;
  logic                      out_rev;
  logic                      out_upd;

  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  amps_wide;
  logic signed [CUR_W-1:0]   amps_sat;
  logic signed [CUR_W-1:0]   old_amps;
  logic signed [MAG_W-1:0]   sum_next;
  logic [Q_W-1:0]            q_est;
  logic [MAG_W-1:0]          rem;
  logic [Q_W-1:0]            q_fix;
  logic                      avg_neg;
  logic signed [CUR_W-1:0]   avg_next;
  logic signed [INC_W-1:0]   inc;
  logic signed [INC_W-1:0]   ival;
  logic signed [INC_W-1:0]   lim;
  logic signed [INTEG_W-1:0] integral_next;
  logic signed [ACC_W-1:0]   biased;
  logic signed [PWMW_W-1:0]  pwm_w;
  logic signed [PWMW_W-1:0]  pm;
  logic signed [PWMW_W-1:0]  pwm_cl;
  logic signed [PWMW_W-1:0]  pwm_abs;
  logic                      in_beat;
  logic                      out_load;

  assign s_tready = (state == ST_IDLE);
  assign in_beat  = s_tvalid && s_tready;
  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);
  assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_mag, out_cur};
  assign m_tuser  = {out_upd, out_rev};

  // shared multiplier operands
  always_comb begin
    diff  = $signed(DIFF_W'(sample)) - $signed(DIFF_W'(zero_code));
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_CONV: begin
        mul_a = MUL_W'(diff);
        mul_b = MUL_W'({1'b0, adc_gain});
      end
      ST_DIV: begin
        mul_a = MUL_W'({1'b0, sum_mag});
        mul_b = MUL_W'({1'b0, RECIP});
      end
      ST_INT: begin
        mul_a = MUL_W'(err);
        mul_b = MUL_W'({1'b0, step_time});
      end
      ST_ACC: begin
        mul_a = MUL_W'(err);
        mul_b = MUL_W'({1'b0, prop_gain});
      end
      ST_PROP: begin
        mul_a = MUL_W'(integral);
        mul_b = MUL_W'({1'b0, integ_gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    amps_wide = prod >>> AMP_SHIFT;
    if ((&amps_wide[PROD_W-1:CUR_W-1]) || !(|amps_wide[PROD_W-1:CUR_W-1])) begin
      amps_sat = amps_wide[CUR_W-1:0];
    end else if (amps_wide[PROD_W-1]) begin
      amps_sat = {1'b1, {(CUR_W-1){1'b0}}};
    end else begin
      amps_sat = {1'b0, {(CUR_W-1){1'b1}}};
    end
    old_amps = rd_valid ? rd_data : '0;
    sum_next = window_sum - MAG_W'(old_amps) + MAG_W'(amps_sat);

    q_est   = prod[MAG_W +: Q_W];
    rem     = sum_mag - MAG_W'(q_est) * WIN_VAL;
    q_fix   = (rem >= WIN_VAL) ? q_est + Q_W'(1) : q_est;
    avg_neg = sum_neg ^ reverse;
    if (avg_neg) begin
      avg_next = CUR_W'(-$signed(q_fix));
    end else if (q_fix[CUR_W-1]) begin
      avg_next = {1'b0, {(CUR_W-1){1'b1}}};
    end else begin
      avg_next = $signed(q_fix[CUR_W-1:0]);
    end

    inc  = $signed(prod[INC_W+AMP_SHIFT-1:AMP_SHIFT]);
    ival = $signed(INC_W'(integral)) + inc;
    lim  = $signed(INC_W'(integral_limit));
    if (ival > lim) begin
      integral_next = INTEG_W'(lim);
    end else if (ival < -lim) begin
      integral_next = INTEG_W'(-lim);
    end else begin
      integral_next = INTEG_W'(ival);
    end

    biased  = acc + (acc[ACC_W-1] ? $signed(TRUNC_BIAS) : $signed(ACC_W'(0)));
    pwm_w   = biased[ACC_W-1:PI_FRAC];
    pm      = $signed(PWMW_W'(pwm_max));
    if (pwm_w > pm) begin
      pwm_cl = pm;
    end else if (pwm_w < -pm) begin
      pwm_cl = -pm;
    end else begin
      pwm_cl = pwm_w;
    end
    pwm_abs = pwm_cl[PWMW_W-1] ? -pwm_cl : pwm_cl;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_current <= RST_TARGET;
      prop_gain      <= RST_PROP_GAIN;
      integ_gain     <= RST_INTEG_GAIN;
      step_time      <= RST_STEP_TIME;
      integral_limit <= RST_INTEG_LIMIT;
      pwm_max        <= RST_PWM_MAX;
      zero_code      <= RST_ZERO_CODE;
      adc_gain       <= RST_ADC_GAIN;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TARGET:      target_current <= cfg_data[CUR_W-1:0];
        REG_PROP_GAIN:   prop_gain      <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN:  integ_gain     <= cfg_data[GAIN_W-1:0];
        REG_STEP_TIME:   step_time      <= cfg_data[GAIN_W-1:0];
        REG_INTEG_LIMIT: integral_limit <= cfg_data[LIMIT_W-1:0];
        REG_PWM_MAX:     pwm_max        <= cfg_data[PWM_W-1:0];
        REG_ZERO_CODE:   zero_code      <= cfg_data[ZERO_W-1:0];
        REG_ADC_GAIN:    adc_gain       <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // sample ring memory
  always_ff @(posedge clk) begin
    if (state == ST_SUM) begin
      ring_mem[ring_pos] <= amps_sat;
    end
    rd_data <= ring_mem[ring_pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      rd_valid <= ring_valid[ring_pos];
      if (state == ST_SUM) begin
        ring_valid[ring_pos] <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (in_beat) begin
      sample  <= s_tdata[ADC_BITS-1:0];
      reverse <= s_tuser[0];
      tick    <= s_tuser[1];
    end
    if (state == ST_SUM) begin
      sum_mag <= sum_next[MAG_W-1] ? MAG_W'(-sum_next) : MAG_W'(sum_next);
      sum_neg <= sum_next[MAG_W-1];
    end
    if (state == ST_CORR) begin
      avg <= avg_next;
    end
    if (state == ST_ERR) begin
      err <= Q_W'(target_current) - Q_W'(avg);
    end
    if (state == ST_PROP) begin
      pterm <= prod;
    end
    if (state == ST_PISUM) begin
      acc <= (ACC_W'(pterm) <<< AMP_SHIFT) + ACC_W'(prod);
    end
    if (out_load) begin
      out_cur <= avg;
    end
  end

  // sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ring_pos   <= '0;
      window_sum <= '0;
      integral   <= '0;
      held_mag   <= '0;
      held_rev   <= 1'b0;
      m_tvalid   <= 1'b0;
      out_mag    <= '0;
      out_rev    <= 1'b0;
      out_upd    <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_beat) begin
            state <= ST_CONV;
          end
        end
        ST_CONV: state <= ST_SUM;
        ST_SUM: begin
          window_sum <= sum_next;
          ring_pos   <= (ring_pos == LAST_POS) ? '0 : ring_pos + POS_W'(1);
          state      <= ST_DIV;
        end
        ST_DIV:  state <= ST_CORR;
        ST_CORR: state <= tick ? ST_ERR : ST_OUT;
        ST_ERR:  state <= ST_INT;
        ST_INT:  state <= ST_ACC;
        ST_ACC: begin
          integral <= integral_next;
          state    <= ST_PROP;
        end
        ST_PROP:  state <= ST_PISUM;
        ST_PISUM: state <= ST_PWM;
        ST_PWM: begin
          held_rev <= pwm_cl[PWMW_W-1];
          held_mag <= pwm_abs[PWM_W-1:0];
          state    <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            out_mag  <= held_mag;
            out_rev  <= held_rev;
            out_upd  <= tick;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `CFPI_ASSERT_NEXT(a_one_beat_in_work, s_tvalid && s_tready, !s_tready)
  `CFPI_ASSERT_HOLD(a_out_from_seq, $rose(m_tvalid), $past(state == ST_OUT))
  `CFPI_ASSERT_NEXT(a_pwm_within_max, state == ST_PWM, held_mag <= pwm_max)
  `CFPI_ASSERT_HOLD(a_pos_in_window, 1'b1, ring_pos <= LAST_POS)

endmodule

// ===== sim/tb_current_filter_pi_controller.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the current filter PI controller
// Streams ADC beats through the block and checks every output beat against a
// behavioural model of the moving-average filter and the PI step. The run
// covers directed extremes, saturating set-ups and random register settings
// under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_current_filter_pi_controller;
  import cfpi_pkg::*;

  localparam int RING_DEPTH = WINDOW_DEF;
  localparam int S_DATA_W   = ((ADC_BITS_DEF + 7) / 8) * 8;
  localparam int STALL_MAX  = 4000;
  localparam int PHASES     = 17;
  localparam int PHASE_BEATS = 100;

  typedef struct packed {
    logic [ADC_BITS_DEF-1:0] adc_sample;
    logic                    motor_reverse;
    logic                    control_tick;
  } adc_beat_t;

  typedef struct packed {
    logic signed [CUR_W-1:0] filtered_current;
    logic [PWM_W-1:0]        pwm_magnitude;
    logic                    pwm_reverse;
    logic                    pwm_updated;
  } ctrl_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata = '0;
  logic [USER_W-1:0]    s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [USER_W-1:0]    m_tuser;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  current_filter_pi_controller dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copies
  logic signed [CUR_W-1:0] target_current = RST_TARGET;
  logic [GAIN_W-1:0]       prop_gain      = RST_PROP_GAIN;
  logic [GAIN_W-1:0]       integ_gain     = RST_INTEG_GAIN;
  logic [GAIN_W-1:0]       step_time      = RST_STEP_TIME;
  logic [LIMIT_W-1:0]      integ_limit    = RST_INTEG_LIMIT;
  logic [PWM_W-1:0]        pwm_max        = RST_PWM_MAX;
  logic [ZERO_W-1:0]       zero_code      = RST_ZERO_CODE;
  logic [GAIN_W-1:0]       adc_gain       = RST_ADC_GAIN;

  // filter and loop state
  logic signed [CUR_W-1:0] amp_ring [RING_DEPTH];
  logic [4:0]              ring_wr = '0;
  longint                  ring_total = 0;
  longint                  integ_acc = 0;
  logic [PWM_W-1:0]        held_mag = '0;
  logic                    held_rev = 1'b0;

  adc_beat_t adc_beats_q[$];
  ctrl_out_t ctrl_results_due[$];
  adc_beat_t beat_on_bus;
  logic      in_taken = 1'b0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        mismatches = 0;
  int        stall_cycles = 0;
  logic      rev_run = 1'b0;

  initial begin
    for (int i = 0; i < RING_DEPTH; i++) amp_ring[i] = '0;
  end

  function automatic longint sat(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic ctrl_out_t run_current_loop(adc_beat_t b);
    longint    amps;
    longint    avg;
    longint    err;
    longint    acc;
    longint    pwm;
    longint    lim;
    ctrl_out_t r;
    amps = ((longint'(b.adc_sample) - longint'(zero_code)) * longint'(adc_gain)) >>> AMP_SHIFT;
    amps = sat(amps, -32768, 32767);
    ring_total = ring_total - longint'(amp_ring[ring_wr]) + amps;
    amp_ring[ring_wr] = CUR_W'(amps);
    ring_wr = ring_wr + 5'd1;
    avg = ring_total / RING_DEPTH;
    if (b.motor_reverse) avg = -avg;
    avg = sat(avg, -32768, 32767);
    if (b.control_tick) begin
      err = longint'(target_current) - avg;
      lim = longint'(integ_limit);
      integ_acc = sat(integ_acc + ((err * longint'(step_time)) >>> 8), -lim, lim);
      acc = err * longint'(prop_gain) * 256 + longint'(integ_gain) * integ_acc;
      pwm = (acc < 0) ? -((-acc) >>> PI_FRAC) : (acc >>> PI_FRAC);
      pwm = sat(pwm, -longint'(pwm_max), longint'(pwm_max));
      held_rev = (pwm < 0);
      held_mag = PWM_W'((pwm < 0) ? -pwm : pwm);
    end
    r.filtered_current = CUR_W'(avg);
    r.pwm_magnitude    = held_mag;
    r.pwm_reverse      = held_rev;
    r.pwm_updated      = b.control_tick;
    return r;
  endfunction

  task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (r)
      REG_TARGET:      target_current = v[CUR_W-1:0];
      REG_PROP_GAIN:   prop_gain      = v[GAIN_W-1:0];
      REG_INTEG_GAIN:  integ_gain     = v[GAIN_W-1:0];
      REG_STEP_TIME:   step_time      = v[GAIN_W-1:0];
      REG_INTEG_LIMIT: integ_limit    = v[LIMIT_W-1:0];
      REG_PWM_MAX:     pwm_max        = v[PWM_W-1:0];
      REG_ZERO_CODE:   zero_code      = v[ZERO_W-1:0];
      REG_ADC_GAIN:    adc_gain       = v[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // kind 0: top extremes, 1: bottom extremes, 2: moderate, 3: anything
  function automatic logic [CFG_DATA_W-1:0] pick_reg_value(cfg_reg_t r, int kind);
    logic [CFG_DATA_W-1:0] junk;
    logic [15:0]           t;
    junk = CFG_DATA_W'($urandom);
    t = 16'(int'($urandom_range(0, 2048)) - 1024);
    case (kind)
      0: return (r == REG_TARGET) ? {junk[22:16], 16'h7FFF} : 23'h7FFFFF;
      1: return (r == REG_TARGET) ? {7'd0, 16'h8000} : 23'd0;
      2: case (r)
        REG_TARGET:      return {junk[22:16], t};
        REG_PROP_GAIN:   return {junk[22:16], 16'($urandom_range(0, 12000))};
        REG_INTEG_GAIN:  return {junk[22:16], 16'($urandom_range(0, 8000))};
        REG_STEP_TIME:   return {junk[22:16], 16'($urandom_range(0, 2000))};
        REG_INTEG_LIMIT: return ($urandom_range(0, 1) != 0) ? 23'($urandom_range(0, 200000))
                                                           : junk;
        REG_PWM_MAX:     return {junk[22:10], 10'($urandom_range(0, 1023))};
        REG_ZERO_CODE:   return {junk[22:12], 12'($urandom_range(1800, 2300))};
        default:         return {junk[22:16], 16'($urandom_range(0, 3000))};
      endcase
      default: return junk;
    endcase
  endfunction

  function automatic adc_beat_t make_beat(logic [11:0] adc, logic rev, logic tick);
    adc_beat_t b;
    b.adc_sample    = adc;
    b.motor_reverse = rev;
    b.control_tick  = tick;
    return b;
  endfunction

  function automatic adc_beat_t random_beat();
    logic [11:0] adc;
    if ($urandom_range(0, 7) == 0) rev_run = ~rev_run;
    case ($urandom_range(0, 9))
      0: adc = 12'd0;
      1: adc = 12'hFFF;
      2, 3: adc = 12'(int'(zero_code) + int'($urandom_range(0, 32)) - 16);
      default: adc = 12'($urandom);
    endcase
    return make_beat(adc, rev_run, 1'($urandom));
  endfunction

  task automatic wait_drained();
    while (adc_beats_q.size() != 0 || s_tvalid || ctrl_results_due.size() != 0)
      @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (adc_beats_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        beat_on_bus = adc_beats_q.pop_front();
        s_tdata  <= S_DATA_W'(beat_on_bus.adc_sample);
        s_tuser  <= {beat_on_bus.control_tick, beat_on_bus.motor_reverse};
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    m_tready <= !rst && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // predict on input beats, check output beats
  always @(posedge clk) begin : mon
    ctrl_out_t want;
    ctrl_out_t got;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) ctrl_results_due.push_back(run_current_loop(beat_on_bus));
      if (m_tvalid && m_tready) begin
        got.filtered_current = m_tdata[CUR_W-1:0];
        got.pwm_magnitude    = m_tdata[CUR_W+PWM_W-1:CUR_W];
        got.pwm_reverse      = m_tuser[0];
        got.pwm_updated      = m_tuser[1];
        if (ctrl_results_due.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected output beat: cur=%0d mag=%0d rev=%0b upd=%0b",
                     got.filtered_current, got.pwm_magnitude, got.pwm_reverse,
                     got.pwm_updated);
          mismatches++;
        end else begin
          want = ctrl_results_due.pop_front();
          if (want != got) begin
            if (mismatches < 10)
              $display("mismatch: exp cur=%0d mag=%0d rev=%0b upd=%0b, got cur=%0d mag=%0d rev=%0b upd=%0b",
                       want.filtered_current, want.pwm_magnitude, want.pwm_reverse,
                       want.pwm_updated, got.filtered_current, got.pwm_magnitude,
                       got.pwm_reverse, got.pwm_updated);
            mismatches++;
          end
        end
      end
    end
  end

  // watchdog: count cycles with work outstanding and no beat moving
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (adc_beats_q.size() == 0 && !s_tvalid && ctrl_results_due.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // directed beats under reset settings
    adc_beats_q.push_back(make_beat(12'd0,    1'b0, 1'b0));
    adc_beats_q.push_back(make_beat(12'hFFF,  1'b0, 1'b1));
    adc_beats_q.push_back(make_beat(12'd2048, 1'b0, 1'b1));
    adc_beats_q.push_back(make_beat(12'd2048, 1'b1, 1'b1));
    adc_beats_q.push_back(make_beat(12'hFFF,  1'b1, 1'b0));
    adc_beats_q.push_back(make_beat(12'd0,    1'b1, 1'b1));
    adc_beats_q.push_back(make_beat(12'd0,    1'b0, 1'b1));
    adc_beats_q.push_back(make_beat(12'd1,    1'b0, 1'b0));
    adc_beats_q.push_back(make_beat(12'd2047, 1'b0, 1'b1));
    adc_beats_q.push_back(make_beat(12'd2049, 1'b1, 1'b1));
    adc_beats_q.push_back(make_beat(12'hAAA,  1'b0, 1'b1));
    adc_beats_q.push_back(make_beat(12'h555,  1'b1, 1'b0));
    wait_drained();

    // fill the window with the most negative sample, then reverse it
    write_reg(REG_ZERO_CODE, 23'd4095);
    write_reg(REG_ADC_GAIN,  23'd65535);
    write_reg(REG_PWM_MAX,   23'd1023);
    for (int i = 0; i < 34; i++)
      adc_beats_q.push_back(make_beat(12'd0, 1'(i >= 31), 1'(i % 2)));
    wait_drained();

    // most positive sample, then zero PI output
    write_reg(REG_ZERO_CODE, 23'd0);
    for (int i = 0; i < 4; i++) adc_beats_q.push_back(make_beat(12'hFFF, 1'b0, 1'b1));
    wait_drained();
    write_reg(REG_PROP_GAIN,  23'd0);
    write_reg(REG_INTEG_GAIN, 23'd0);
    for (int i = 0; i < 3; i++) adc_beats_q.push_back(make_beat(12'hFFF, 1'(i), 1'b1));
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      for (int r = 0; r < 8; r++)
        write_reg(cfg_reg_t'(r), pick_reg_value(cfg_reg_t'(r),
                  (p < 2) ? p : ((p % 3 == 0) ? 3 : 2)));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      for (int i = 0; i < PHASE_BEATS; i++) adc_beats_q.push_back(random_beat());
      wait_drained();
    end

    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== current_filter_pi_controller.f =====
+incdir+design
design/cfpi_pkg.sv
design/current_filter_pi_controller.sv
sim/tb_current_filter_pi_controller.sv
